[rtl/dmco_pkg.sv]
// Package with payload types and fixed-point constants for the coldest-first ordering block.
`default_nettype none
package dmco_pkg;

    localparam int unsigned Q16_ONE  = 65536;
    localparam int unsigned Q16_HALF = 32768;
    localparam int unsigned AGE_BITS = 32;

    localparam logic [1:0] REG_CURRENT_STEP = 2'd0;
    localparam logic [1:0] REG_DECAY_RATE   = 2'd1;
    localparam int unsigned CFG_INDEX_WIDTH = 2;
    localparam int unsigned CFG_DATA_WIDTH  = 32;

    typedef struct packed {
        logic [31:0] mass_q24;
        logic [31:0] recorded_step;
        logic        batch_end;
    } item_t;

    typedef struct packed {
        logic [5:0]  page_index;
        logic [31:0] effective_mass;
        logic        order_end;
    } result_t;

endpackage
`default_nettype wire

[rtl/decayed_mass_coldest_order.sv]
// Top level of the decayed-mass coldest-first ordering block.
//
//   channel  | handshake           | payload
//   ---------+---------------------+----------------------------------------
//   command  | start / busy        | item   (mass_q24, recorded_step, batch_end)
//   result   | result_valid strobe | result (page_index, effective_mass, order_end)
//   config   | cfg_we              | cfg_index, cfg_data
//
// A transaction on the command port is accepted when start is high and busy is low.
// Each page first raises the keep factor to its age by square-and-multiply in the shared
// Q1.16 multiplier, then scales its mass in the same multiplier, and then a stable
// insertion walks the order memory one entry at a time (read order, read mass, compare
// and write back). Busy stays high until the insertion is done, so no new page is taken
// before then. On batch end the order is read back from the two memories, one result at
// a time (read order, read mass, emit). The result strobe lasts one cycle; the receiver
// cannot stall, so no result is ever held. Reset clears control state only; the memories
// need no clearing pass, since only entries written in the current batch are read.
`default_nettype none
module decayed_mass_coldest_order #(
    parameter int unsigned MAX_PAGES = 64
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    start,
    output logic                                         busy,
    input  wire dmco_pkg::item_t                         item,
    output logic                                         result_valid,
    output dmco_pkg::result_t                            result,
    input  wire logic                                    cfg_we,
    input  wire logic [dmco_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  wire logic [dmco_pkg::CFG_DATA_WIDTH-1:0]     cfg_data
);
    import dmco_pkg::*;

    localparam int unsigned IW = $clog2(MAX_PAGES);
    localparam int unsigned CW = $clog2(MAX_PAGES + 1);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_POWER  = 9'b000000010,
        S_SCALE  = 9'b000000100,
        S_IREAD  = 9'b000001000,
        S_ICMP   = 9'b000010000,
        S_EREAD  = 9'b000100000,
        S_EMASS  = 9'b001000000,
        S_EOUT   = 9'b010000000,
        S_EMIT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [31:0] current_step_reg;
    logic [15:0] decay_rate_reg;
    logic [CW-1:0] loaded_count_reg;

    // Working registers of one page.
    logic [31:0] age_reg;
    logic [16:0] pow_reg;
    logic [16:0] base_reg;
    logic [5:0]  step_reg;
    logic [31:0] mass_reg;
    logic        last_reg;
    logic [31:0] eff_reg;
    logic [CW-1:0] k_reg;
    logic [IW-1:0] prev_idx_reg;

    // Memories.
    logic [31:0]   decayed_mem [MAX_PAGES];
    logic [IW-1:0] order_mem   [MAX_PAGES];
    logic [31:0]   decayed_rd;
    logic [IW-1:0] order_rd;
    logic [IW-1:0] order_raddr;
    logic [IW-1:0] decayed_raddr;
    logic          order_we;
    logic [IW-1:0] order_waddr;
    logic [IW-1:0] order_wdata;
    logic          decayed_we;

    // Shared multiplier: Q1.16 by Q1.16, or mass by Q1.16.
    logic [31:0] mul_a;
    logic [16:0] mul_b;
    logic [48:0] mul_p;
    logic [32:0] mul_rnd;

    always_comb
    begin
        mul_a = {15'd0, base_reg};
        mul_b = base_reg;
        if (state_reg == S_POWER && age_reg[0])
        begin
            mul_a = {15'd0, pow_reg};
        end
        else if (state_reg == S_SCALE)
        begin
            mul_a = mass_reg;
            mul_b = pow_reg;
        end
        mul_p   = 49'(mul_a) * 49'(mul_b);
        mul_rnd = 33'((mul_p + 49'(Q16_HALF)) >> 16);
    end

    always_ff @(posedge clk)
    begin
        if (order_we)
        begin
            order_mem[order_waddr] <= order_wdata;
        end
        order_rd <= order_mem[order_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (decayed_we)
        begin
            decayed_mem[loaded_count_reg[IW-1:0]] <= eff_reg;
        end
        decayed_rd <= decayed_mem[decayed_raddr];
    end

    logic accept;
    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        order_raddr   = k_reg[IW-1:0] - IW'(1);
        decayed_raddr = order_rd;
        order_we      = 1'b0;
        order_waddr   = k_reg[IW-1:0];
        order_wdata   = loaded_count_reg[IW-1:0];
        decayed_we    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (loaded_count_reg < CW'(MAX_PAGES)) ? S_POWER
                               : (item.batch_end ? S_EREAD : S_IDLE);
                end
            end
            S_POWER:
            begin
                // All 32 age bits have been consumed once the step count reaches 32.
                if (step_reg == 6'(AGE_BITS))
                begin
                    state_next = S_SCALE;
                end
            end
            S_SCALE:
            begin
                state_next = S_IREAD;
            end
            S_IREAD:
            begin
                if (k_reg == '0)
                begin
                    order_we   = 1'b1;
                    decayed_we = 1'b1;
                    state_next = last_reg ? S_EREAD : S_IDLE;
                end
                else
                begin
                    state_next = S_ICMP;
                end
            end
            S_ICMP:
            begin
                // order_rd holds order[k-1]; its mass is read during this cycle.
                state_next = S_EMASS;
            end
            S_EMASS:
            begin
                if (decayed_rd > eff_reg)
                begin
                    order_we    = 1'b1;
                    order_wdata = prev_idx_reg;
                    state_next  = S_IREAD;
                end
                else
                begin
                    order_we   = 1'b1;
                    decayed_we = 1'b1;
                    state_next = last_reg ? S_EREAD : S_IDLE;
                end
            end
            S_EREAD:
            begin
                order_raddr = k_reg[IW-1:0];
                state_next  = (loaded_count_reg == '0) ? S_IDLE : S_EOUT;
            end
            S_EOUT:
            begin
                // The order entry is in order_rd; its mass is read during this cycle.
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                state_next = (k_reg + CW'(1) == loaded_count_reg) ? S_IDLE : S_EREAD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            current_step_reg <= '0;
            decay_rate_reg   <= '0;
            loaded_count_reg <= '0;
            result_valid     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            result_valid <= (state_reg == S_EMIT);
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_CURRENT_STEP: current_step_reg <= cfg_data;
                    REG_DECAY_RATE:   decay_rate_reg   <= cfg_data[15:0];
                    default:          ;
                endcase
            end
            if ((state_reg == S_IREAD && k_reg == '0)
                || (state_reg == S_EMASS && !(decayed_rd > eff_reg)))
            begin
                loaded_count_reg <= loaded_count_reg + CW'(1);
            end
            else if (state_reg == S_EMIT && k_reg + CW'(1) == loaded_count_reg)
            begin
                loaded_count_reg <= '0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                age_reg  <= (current_step_reg > item.recorded_step)
                          ? current_step_reg - item.recorded_step : 32'd0;
                pow_reg  <= 17'(Q16_ONE);
                base_reg <= 17'(Q16_ONE) - {1'b0, decay_rate_reg};
                step_reg <= '0;
                mass_reg <= item.mass_q24;
                last_reg <= item.batch_end;
                k_reg    <= (loaded_count_reg < CW'(MAX_PAGES)) ? loaded_count_reg : '0;
            end
            S_POWER:
            begin
                // Each multiply step uses the multiplier for p, the next cycle squares b.
                if (age_reg[0])
                begin
                    pow_reg    <= mul_rnd[16:0];
                    age_reg[0] <= 1'b0;
                end
                else
                begin
                    base_reg <= mul_rnd[16:0];
                    age_reg  <= age_reg >> 1;
                    step_reg <= step_reg + 6'd1;
                end
            end
            S_SCALE:
            begin
                eff_reg <= mul_rnd[31:0];
            end
            S_ICMP:
            begin
                prev_idx_reg <= order_rd;
            end
            S_EMASS:
            begin
                if (decayed_rd > eff_reg)
                begin
                    k_reg <= k_reg - CW'(1);
                end
                else if (last_reg)
                begin
                    k_reg <= '0;
                end
            end
            S_IREAD:
            begin
                if (k_reg == '0 && last_reg)
                begin
                    k_reg <= '0;
                end
            end
            S_EMIT:
            begin
                k_reg <= k_reg + CW'(1);
            end
            default:
            begin
            end
        endcase
    end

    // The order entry is captured in S_EOUT while its mass is read; in S_EMIT both
    // are registered onto the result ports together with the strobe.
    logic [IW-1:0] out_idx_reg;
    always_ff @(posedge clk)
    begin
        if (state_reg == S_EOUT)
        begin
            out_idx_reg <= order_rd;
        end
        if (state_reg == S_EMIT)
        begin
            result.page_index     <= 6'(out_idx_reg);
            result.effective_mass <= decayed_rd;
            result.order_end      <= (k_reg + CW'(1) == loaded_count_reg);
        end
    end

endmodule
`default_nettype wire

[rtl/dmco_checker.sv]
// Port-level checker for the coldest-first ordering block, bound to the top level.
`default_nettype none
module dmco_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire logic             result_valid,
    input wire dmco_pkg::result_t result
);
    import dmco_pkg::*;

    a_no_result_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !result_valid)
        else $error("result strobe right after an accepted transaction");

    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("results came on back-to-back cycles");

    a_end_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.order_end) |-> !busy)
        else $error("block still busy at the end of an ordering");

    a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.order_end) |-> busy)
        else $error("result outside an ordering");

endmodule

bind decayed_mass_coldest_order dmco_checker u_dmco_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);
`default_nettype wire

[dv/tb.sv]
// Testbench for the decayed-mass coldest-first ordering block.
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import dmco_pkg::*;

    logic                       clk;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    item_t                      item;
    logic                       result_valid;
    result_t                    result;
    logic                       cfg_we;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data;

    // Model copy of the configuration and of the pages held in the open batch.
    logic [31:0] model_step;
    logic [15:0] model_decay;
    logic [31:0] batch_mass[$];

    // Ordered results still owed by the block.
    result_t     owed_order[$];
    int          error_count;

    decayed_mass_coldest_order i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // The keep factor raised to the age, by square-and-multiply in Q1.16 with
    // round-half-up on every product.
    function automatic logic [63:0] keep_power(input logic [31:0] age);
        logic [63:0] p;
        logic [63:0] b;
        p = 64'(Q16_ONE);
        b = 64'(Q16_ONE) - 64'(model_decay);
        for (int i = 0; i < AGE_BITS; i++)
        begin
            if (age[i])
                p = (p * b + 64'(Q16_HALF)) >> 16;
            b = (b * b + 64'(Q16_HALF)) >> 16;
        end
        return p;
    endfunction

    function automatic logic [31:0] decayed_mass(input logic [31:0] mass,
                                                 input logic [31:0] rec);
        logic [31:0] age;
        logic [63:0] r;
        // A record from the future has age zero.
        age = (model_step > rec) ? model_step - rec : 32'd0;
        r   = (64'(mass) * keep_power(age) + 64'(Q16_HALF)) >> 16;
        return r[31:0];
    endfunction

    // Update the model for one accepted page. On batch end, the stable
    // ascending order of the held pages is queued as owed results.
    task automatic absorb_page(input item_t pg);
        int      order[$];
        int      k;
        result_t r;
        // Pages beyond the store's capacity are dropped.
        if (batch_mass.size() < 64)
            batch_mass.push_back(decayed_mass(pg.mass_q24, pg.recorded_step));
        if (pg.batch_end)
        begin
            foreach (batch_mass[i])
            begin
                // Insert after every entry that is not greater, which keeps ties
                // in load order.
                k = order.size();
                while (k > 0 && batch_mass[order[k-1]] > batch_mass[i])
                    k--;
                order.insert(k, i);
            end
            foreach (order[i])
            begin
                r.page_index     = 6'(order[i]);
                r.effective_mass = batch_mass[order[i]];
                r.order_end      = (i == order.size() - 1);
                owed_order.push_back(r);
            end
            batch_mass.delete();
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("tb: mismatch on %s: expected %0h, got %0h at %0t", what, want, got, $realtime);
        error_count++;
    endtask

    // Result checker: every strobe is compared with the oldest owed result.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid)
        begin
            if (owed_order.size() == 0)
                report_mismatch("unexpected result", 32'd0, 32'(result.page_index));
            else
            begin
                want = owed_order.pop_front();
                if (result.page_index !== want.page_index)
                    report_mismatch("page_index", 32'(want.page_index), 32'(result.page_index));
                if (result.effective_mass !== want.effective_mass)
                    report_mismatch("effective_mass", want.effective_mass,
                                    result.effective_mass);
                if (result.order_end !== want.order_end)
                    report_mismatch("order_end", 32'(want.order_end), 32'(result.order_end));
            end
        end
    end

    // Mostly short gaps, with an occasional long one.
    function automatic int gap_cycles();
        if ($urandom_range(0, 9) < 4)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Send one page transaction and wait until the block accepts it. Start stays
    // high into the next transaction when no gap follows.
    task automatic send_page(input logic [31:0] mass, input logic [31:0] rec,
                             input logic last);
        item_t pg;
        int    gap;
        pg.mass_q24      = mass;
        pg.recorded_step = rec;
        pg.batch_end     = last;
        start <= 1'b1;
        item  <= pg;
        do
            @(posedge clk);
        while (busy);
        absorb_page(pg);
        gap = gap_cycles();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap)
                @(posedge clk);
        end
    endtask

    // Wait for the ordering to drain, then let the block settle before any
    // register write.
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (owed_order.size() != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_CURRENT_STEP)
            model_step = value;
        else if (idx == REG_DECAY_RATE)
            model_decay = value[15:0];
        @(posedge clk);
    endtask

    task automatic set_config(input logic [31:0] step_value, input logic [15:0] decay_value);
        wait_idle();
        write_reg(REG_CURRENT_STEP, step_value);
        write_reg(REG_DECAY_RATE, 32'(decay_value));
    endtask

    // Field extremes, future records, zero and full decay, ties and a huge age.
    task automatic test_directed_extremes();
        // Reset values of the registers: zero decay leaves masses unchanged.
        send_page(32'hFFFF_FFFF, 32'd0, 1'b0);
        send_page(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        send_page(32'h0100_0000, 32'd5, 1'b1);
        set_config(32'd1000, 16'd4096);
        send_page(32'h0100_0000, 32'd999, 1'b0);
        send_page(32'h0100_0000, 32'd2000, 1'b0);
        send_page(32'h0100_0000, 32'd2000, 1'b0);
        send_page(32'hFFFF_FFFF, 32'd0, 1'b0);
        send_page(32'h8000_0000, 32'd1000, 1'b1);
        set_config(32'hFFFF_FFFF, 16'hFFFF);
        send_page(32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0);
        send_page(32'hFFFF_FFFF, 32'd0, 1'b0);
        send_page(32'h1234_5678, 32'hFFFF_FFFF, 1'b1);
        set_config(32'hFFFF_FFFF, 16'd0);
        send_page(32'hAAAA_5555, 32'd0, 1'b1);
        set_config(32'd0, 16'd1);
        send_page(32'h5555_AAAA, 32'd1, 1'b0);
        send_page(32'h0000_0001, 32'd0, 1'b1);
    endtask

    // A batch longer than the store: the excess is dropped and the end marker on
    // a dropped page still releases the ordering.
    task automatic test_store_full();
        set_config(32'd100, 16'd300);
        for (int i = 0; i < 66; i++)
            send_page($urandom_range(0, 3) == 0 ? 32'h0100_0000 : $urandom(),
                      32'd100 - 32'($urandom_range(0, 120)), i == 65);
    endtask

    task automatic test_random_batches();
        int          sent;
        int          size;
        logic [31:0] step_value;
        logic [15:0] decay_value;
        logic [31:0] rec;
        sent = 0;
        while (sent < 300)
        begin
            case ($urandom_range(0, 5))
                0:       decay_value = 16'd0;
                1:       decay_value = 16'hFFFF;
                2:       decay_value = 16'($urandom_range(1, 255));
                default: decay_value = 16'($urandom());
            endcase
            step_value = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF : $urandom();
            set_config(step_value, decay_value);
            size = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
            for (int i = 0; i < size; i++)
            begin
                case ($urandom_range(0, 7))
                    0:       rec = $urandom();
                    1:       rec = step_value + 32'($urandom_range(1, 50));
                    2:       rec = step_value;
                    default: rec = step_value - 32'($urandom_range(1, 64));
                endcase
                // A few pages share one mass so that ties appear.
                send_page(($urandom_range(0, 4) == 0) ? 32'h0080_0000 : $urandom(), rec,
                          i == size - 1);
                sent++;
            end
        end
    endtask

    initial
    begin
        error_count = 0;
        model_step  = 32'd0;
        model_decay = 16'd0;
        rst_n       = 1'b0;
        start       = 1'b0;
        item        = '0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_extremes();
        test_store_full();
        test_random_batches();
        wait_idle();
        repeat (200)
            @(posedge clk);
        if (error_count == 0 && owed_order.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #20ms;
        $display("tb: FAIL");
        $finish;
    end

endmodule
`default_nettype wire
